[rtl/assert_macros.svh]
// assertion macros shared by the terminal engine rtl
// the modules that use them must have ports named clk and rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_HOLDS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_HOLDS(label, cond)
`define ASSERT_IMPLIES(label, ante, cons)
`endif
`endif

[rtl/tte_pkg.sv]
// types, codes and helpers for the text terminal character engine
// no dependencies; imported by every module of the block
package tte_pkg;

    localparam int DEF_MAX_COLUMNS = 128;
    localparam int DEF_MAX_ROWS    = 64;
    localparam int DEF_LEFT_CODE   = 128;
    localparam int DEF_RIGHT_CODE  = 129;
    localparam int DEF_UP_CODE     = 130;
    localparam int DEF_DOWN_CODE   = 131;

    localparam logic [7:0] COLUMNS_RST = 8'd80;
    localparam logic [6:0] ROWS_RST    = 7'd25;

    localparam logic CFG_IDX_COLUMNS = 1'b0;
    localparam logic CFG_IDX_ROWS    = 1'b1;

    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_UP_L   = 8'h55;
    localparam logic [7:0] CH_DOWN_L = 8'h44;
    localparam logic [7:0] CH_LEFT_L = 8'h4C;
    localparam logic [7:0] CH_RGHT_L = 8'h52;
    localparam logic [7:0] CH_HOME_L = 8'h48;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] HEX_BAD   = 8'hFF;

    localparam logic [31:0] ROW_STEP = 32'd80;
    localparam logic [3:0]  FORE_RST = 4'd15;
    localparam logic [3:0]  BACK_RST = 4'd0;

    localparam int QUEUE_DEPTH = 2;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [2:0] {
        OP_PRINT, OP_UP, OP_DOWN, OP_LEFT, OP_RIGHT, OP_HOME, OP_FORE, OP_BACK
    } op_code_t;

    typedef struct packed {
        op_code_t   code;
        logic [7:0] data;
    } op_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } q_head_t;

    typedef enum logic [1:0] {TGT_NONE, TGT_FORE, TGT_BACK} target_t;

    typedef enum logic [1:0] {
        KIND_CELL   = 2'd0,
        KIND_SCROLL = 2'd1,
        KIND_CURSOR = 2'd2
    } kind_t;

    typedef struct packed {
        logic [5:0]  cursor_row;
        logic [6:0]  cursor_column;
        logic [15:0] cell_word;
        logic [12:0] cell_address;
        logic [1:0]  kind;
    } result_t;

    // kind travels on tuser, the rest fills tdata
    localparam int OUT_PAD_W = OUT_TDATA_W - $bits(result_t) + $bits(kind_t);

    typedef enum logic [2:0] {
        BK_IDLE, BK_NL_DIV, BK_CELL, BK_POST, BK_POS_DIV, BK_EMIT
    } bk_state_t;

    function automatic logic [7:0] hex_digit(input logic [7:0] c);
        logic [7:0] d;
        d = HEX_BAD;
        if (c >= 8'h30 && c <= 8'h39)
            d = c - 8'h30;
        else if (c >= 8'h41 && c <= 8'h46)
            d = c - 8'h37;
        else if (c >= 8'h61 && c <= 8'h66)
            d = c - 8'h57;
        return d;
    endfunction

endpackage

[rtl/tte_front.sv]
// front end: takes input bytes, decodes backslash and dollar escapes
// depends on tte_pkg; pushes one operation per byte that has an effect
module tte_front import tte_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // char_byte[7:0]
    input  logic       q_full,
    output logic       push,
    output op_t        push_op
);

    logic       bslash_reg, bslash_next;
    logic       dollar_reg, dollar_next;
    target_t    target_reg, target_next;
    logic [1:0] hcount_reg, hcount_next;
    logic [7:0] hacc_reg, hacc_next;
    logic       accept;
    logic       op_valid;
    logic [7:0] c;
    logic [7:0] d;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign push          = accept && op_valid;
    assign c             = s_axis_tdata;
    assign d             = hex_digit(c);

    always_comb
    begin
        bslash_next  = bslash_reg;
        dollar_next  = dollar_reg;
        target_next  = target_reg;
        hcount_next  = hcount_reg;
        hacc_next    = hacc_reg;
        op_valid     = 1'b0;
        push_op.code = OP_PRINT;
        push_op.data = c;
        if (bslash_reg)
        begin
            bslash_next = 1'b0;
            if (c == CH_BSLASH || c == CH_DOLLAR)
                op_valid = 1'b1;
            else if (c == CH_N)
            begin
                op_valid     = 1'b1;
                push_op.data = CH_LF;
            end
        end
        else if (dollar_reg)
        begin
            if (c == CH_BANG)
                target_next = TGT_FORE;
            else if (c == CH_STAR)
                target_next = TGT_BACK;
            else if (c == CH_UP_L || c == CH_DOWN_L || c == CH_LEFT_L ||
                     c == CH_RGHT_L || c == CH_HOME_L)
            begin
                op_valid    = 1'b1;
                dollar_next = 1'b0;
                if (c == CH_UP_L)
                    push_op.code = OP_UP;
                else if (c == CH_DOWN_L)
                    push_op.code = OP_DOWN;
                else if (c == CH_LEFT_L)
                    push_op.code = OP_LEFT;
                else if (c == CH_RGHT_L)
                    push_op.code = OP_RIGHT;
                else
                    push_op.code = OP_HOME;
            end
            else if (c == CH_X)
                hcount_next = 2'd1;
            else if (hcount_reg != 2'd0)
            begin
                // an invalid digit ors in all ones
                hacc_next   = {hacc_reg[3:0], 4'b0000} | d;
                hcount_next = hcount_reg + 2'd1;
                if (hcount_reg == 2'd2)
                begin
                    op_valid     = 1'b1;
                    push_op.data = hacc_next;
                    hacc_next    = 8'h00;
                    hcount_next  = 2'd0;
                    dollar_next  = 1'b0;
                end
            end
            else
            begin
                if (d != HEX_BAD && target_reg == TGT_FORE)
                begin
                    op_valid     = 1'b1;
                    push_op.code = OP_FORE;
                    push_op.data = d;
                end
                else if (d != HEX_BAD && target_reg == TGT_BACK)
                begin
                    op_valid     = 1'b1;
                    push_op.code = OP_BACK;
                    push_op.data = d;
                end
                target_next = TGT_NONE;
                dollar_next = 1'b0;
            end
        end
        else if (c[7])
            op_valid = 1'b1;
        else if (c == CH_BSLASH)
            bslash_next = 1'b1;
        else if (c == CH_DOLLAR)
            dollar_next = 1'b1;
        else
            op_valid = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bslash_reg <= 1'b0;
            dollar_reg <= 1'b0;
            target_reg <= TGT_NONE;
            hcount_reg <= 2'd0;
            hacc_reg   <= 8'h00;
        end
        else if (accept)
        begin
            bslash_reg <= bslash_next;
            dollar_reg <= dollar_next;
            target_reg <= target_next;
            hcount_reg <= hcount_next;
            hacc_reg   <= hacc_next;
        end
    end

endmodule

[rtl/tte_queue.sv]
// short operation queue between the escape decoder and the screen engine
// depends on tte_pkg and assert_macros.svh
`include "assert_macros.svh"
module tte_queue import tte_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  op_t     push_op,
    output logic    full,
    input  logic    pop,
    output q_head_t head
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    op_t           entry_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [CW-1:0] count_reg;

    assign full       = count_reg == CW'(QUEUE_DEPTH);
    assign head.valid = count_reg != '0;
    assign head.op    = entry_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_reg] <= push_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (pop)
                rd_reg <= (rd_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    `ASSERT_IMPLIES(a_no_push_full, push, !full)
    `ASSERT_IMPLIES(a_no_pop_empty, pop, head.valid)
    `ASSERT_HOLDS(a_count_range, count_reg <= CW'(QUEUE_DEPTH))

endmodule

[rtl/tte_back.sv]
// screen engine: cursor, colours, control rules, cell, scroll and cursor results
// depends on tte_pkg and assert_macros.svh; divides by the row width 4 bits a cycle
`include "assert_macros.svh"
module tte_back import tte_pkg::*; #(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int LEFT_CODE   = DEF_LEFT_CODE,
    parameter int RIGHT_CODE  = DEF_RIGHT_CODE,
    parameter int UP_CODE     = DEF_UP_CODE,
    parameter int DOWN_CODE   = DEF_DOWN_CODE
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [7:0]             columns,
    input  logic [6:0]             rows,
    input  q_head_t                head,
    output logic                   pop,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // cell_address[12:0], cell_word[28:13], cursor_column[35:29],
    // cursor_row[41:36], zero fill above
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [1:0]             m_axis_tuser,   // kind[1:0]
    output logic                   m_axis_tlast
);

    localparam int WW        = $clog2(MAX_COLUMNS + 1);
    localparam int RW        = $clog2(MAX_ROWS + 1);
    localparam int AW        = $clog2(MAX_COLUMNS * MAX_ROWS + 1);
    localparam int DIG       = 4;
    localparam int DIV_STEPS = 32 / DIG;
    localparam int SW        = $clog2(DIV_STEPS);

    bk_state_t      state_reg, state_next;
    logic [31:0]    cursor_reg, cursor_next;
    logic [3:0]     fore_reg, fore_next;
    logic [3:0]     back_reg, back_next;
    logic [7:0]     ch_reg, ch_next;
    logic           adv_reg, adv_next;
    logic [WW-1:0]  rem_reg, rem_next;
    logic [31:0]    dq_reg, dq_next;
    logic [SW-1:0]  step_reg, step_next;
    logic           out_valid_reg, out_valid_next;
    result_t        out_data_reg, out_data_next;
    logic           out_last_reg, out_last_next;
    logic           out_load;
    logic [AW-1:0]  area_reg;
    logic [WW-1:0]  eff_w;
    logic [RW-1:0]  eff_r;
    logic [8:0]     col_ext;
    logic [7:0]     row_ext;
    logic [31:0]    w32;
    logic [31:0]    area32;
    logic           can_load;
    logic           in_screen;
    logic [WW-1:0]  div_rem;
    logic [31:0]    div_dq;

    // out-of-range sizes clamp to the legal range
    always_comb
    begin
        col_ext = {1'b0, columns};
        row_ext = {1'b0, rows};
        if (col_ext == 9'd0)
            col_ext = 9'd1;
        else if (col_ext > 9'(MAX_COLUMNS))
            col_ext = 9'(MAX_COLUMNS);
        if (row_ext == 8'd0)
            row_ext = 8'd1;
        else if (row_ext > 8'(MAX_ROWS))
            row_ext = 8'(MAX_ROWS);
        eff_w = WW'(col_ext);
        eff_r = RW'(row_ext);
    end

    always_ff @(posedge clk)
    begin
        area_reg <= AW'(eff_w * eff_r);
    end

    assign w32       = 32'(eff_w);
    assign area32    = 32'(area_reg);
    assign in_screen = cursor_reg < area32;
    assign can_load  = !out_valid_reg || m_axis_tready;

    // restoring division, four quotient bits a cycle
    always_comb
    begin
        logic [WW:0] t;
        div_rem = rem_reg;
        div_dq  = dq_reg;
        for (int i = 0; i < DIG; i++)
        begin
            t      = {div_rem, div_dq[31]};
            div_dq = {div_dq[30:0], 1'b0};
            if (t >= {1'b0, eff_w})
            begin
                t         = t - {1'b0, eff_w};
                div_dq[0] = 1'b1;
            end
            div_rem = t[WW-1:0];
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cursor_next   = cursor_reg;
        fore_next     = fore_reg;
        back_next     = back_reg;
        ch_next       = ch_reg;
        adv_next      = adv_reg;
        rem_next      = rem_reg;
        dq_next       = dq_reg;
        step_next     = step_reg;
        out_load      = 1'b0;
        out_data_next = out_data_reg;
        out_last_next = out_last_reg;
        pop           = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    unique case (head.op.code)
                        OP_UP:    cursor_next = cursor_reg - ROW_STEP;
                        OP_DOWN:  cursor_next = cursor_reg + ROW_STEP;
                        OP_LEFT:  cursor_next = cursor_reg - 32'd1;
                        OP_RIGHT: cursor_next = cursor_reg + 32'd1;
                        OP_HOME:  cursor_next = 32'd0;
                        OP_FORE:  fore_next = head.op.data[3:0];
                        OP_BACK:  back_next = head.op.data[3:0];
                        OP_PRINT:
                        begin
                            ch_next    = head.op.data;
                            adv_next   = 1'b0;
                            state_next = BK_POST;
                            if (head.op.data == CH_LF)
                            begin
                                rem_next   = '0;
                                dq_next    = cursor_reg;
                                step_next  = '0;
                                state_next = BK_NL_DIV;
                            end
                            else if (head.op.data == CH_CR)
                                cursor_next = cursor_reg + w32;
                            else if (head.op.data == CH_TAB)
                                cursor_next = (cursor_reg | 32'd3) + 32'd1;
                            else if (head.op.data == CH_BS)
                            begin
                                cursor_next = cursor_reg - 32'd1;
                                ch_next     = CH_SPACE;
                                state_next  = BK_CELL;
                            end
                            else if (head.op.data == 8'(LEFT_CODE))
                                cursor_next = cursor_reg - 32'd1;
                            else if (head.op.data == 8'(RIGHT_CODE))
                                cursor_next = cursor_reg + 32'd1;
                            else if (head.op.data == 8'(UP_CODE))
                                cursor_next = cursor_reg - w32;
                            else if (head.op.data == 8'(DOWN_CODE))
                                cursor_next = cursor_reg + w32;
                            else
                            begin
                                adv_next   = 1'b1;
                                state_next = BK_CELL;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            BK_NL_DIV:
            begin
                rem_next  = div_rem;
                dq_next   = div_dq;
                step_next = step_reg + 1'b1;
                if (step_reg == SW'(DIV_STEPS - 1))
                begin
                    cursor_next = cursor_reg + w32 - 32'(div_rem);
                    state_next  = BK_POST;
                end
            end
            BK_CELL:
            begin
                // writes past the screen end are dropped
                if (!in_screen || can_load)
                begin
                    if (in_screen)
                    begin
                        out_load                   = 1'b1;
                        out_data_next.kind         = KIND_CELL;
                        out_data_next.cell_address = 13'(cursor_reg);
                        out_data_next.cell_word    = {back_reg, fore_reg, ch_reg};
                        out_data_next.cursor_column = 7'd0;
                        out_data_next.cursor_row   = 6'd0;
                        out_last_next              = 1'b0;
                    end
                    cursor_next = cursor_reg + 32'(adv_reg);
                    state_next  = BK_POST;
                end
            end
            BK_POST:
            begin
                if (!in_screen)
                begin
                    if (can_load)
                    begin
                        out_load                   = 1'b1;
                        out_data_next.kind         = KIND_SCROLL;
                        out_data_next.cell_address = 13'd0;
                        out_data_next.cell_word    = {back_reg, fore_reg, CH_SPACE};
                        out_data_next.cursor_column = 7'd0;
                        out_data_next.cursor_row   = 6'd0;
                        out_last_next              = 1'b1;
                        cursor_next                = area32 - w32;
                        state_next                 = BK_IDLE;
                    end
                end
                else
                begin
                    rem_next   = '0;
                    dq_next    = cursor_reg;
                    step_next  = '0;
                    state_next = BK_POS_DIV;
                end
            end
            BK_POS_DIV:
            begin
                rem_next  = div_rem;
                dq_next   = div_dq;
                step_next = step_reg + 1'b1;
                if (step_reg == SW'(DIV_STEPS - 1))
                    state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (can_load)
                begin
                    out_load                    = 1'b1;
                    out_data_next.kind          = KIND_CURSOR;
                    out_data_next.cell_address  = 13'd0;
                    out_data_next.cell_word     = 16'd0;
                    out_data_next.cursor_column = 7'(rem_reg);
                    out_data_next.cursor_row    = 6'(dq_reg);
                    out_last_next               = 1'b1;
                    state_next                  = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            cursor_reg    <= 32'd0;
            fore_reg      <= FORE_RST;
            back_reg      <= BACK_RST;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            fore_reg      <= fore_next;
            back_reg      <= back_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg       <= ch_next;
        adv_reg      <= adv_next;
        rem_reg      <= rem_next;
        dq_reg       <= dq_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_data_reg.cursor_row,
                            out_data_reg.cursor_column, out_data_reg.cell_word,
                            out_data_reg.cell_address};
    assign m_axis_tuser  = out_data_reg.kind;
    assign m_axis_tlast  = out_last_reg;

    `ASSERT_IMPLIES(a_cell_not_last,
        out_valid_reg && out_data_reg.kind == KIND_CELL, !out_last_reg)
    `ASSERT_IMPLIES(a_final_is_last,
        out_valid_reg && out_data_reg.kind != KIND_CELL, out_last_reg)
    `ASSERT_IMPLIES(a_pos_on_screen, state_reg == BK_POS_DIV, in_screen)

endmodule

[rtl/text_terminal_char_engine.sv]
// Text terminal character engine. Bytes enter on the s_axis channel (one byte
// per item in tdata[7:0]); results leave on m_axis: a cell write, a scroll of
// the screen or a hardware cursor update (kind on tuser), with tlast on the
// final result of a byte. A byte gives 0 to 2 results.
// Configuration: cfg_we writes cfg_data into columns (index 0) or rows
// (index 1); write only while no byte is in flight.
// The front decodes escapes at one byte a cycle while the two-entry queue it feeds is not full.
// The back runs each operation: cursor moves and colour sets end in idle, a
// printed byte passes the cell and post states, then divide and emit (or a
// scroll), a newline a divide before post; the cursor row and column come
// from a shared divider, 4 quotient bits a cycle, setting the sustained rate.
// Reset puts the cursor at 0, colours at white on black, the size at 80x25,
// and clears escape state and queue. When m_axis_tready is low the result
// holds in the output register, the back waits, and once the queue fills
// s_axis_tready drops.
// depends on tte_pkg, tte_front, tte_queue, tte_back
module text_terminal_char_engine import tte_pkg::*; #(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int LEFT_CODE   = DEF_LEFT_CODE,
    parameter int RIGHT_CODE  = DEF_RIGHT_CODE,
    parameter int UP_CODE     = DEF_UP_CODE,
    parameter int DOWN_CODE   = DEF_DOWN_CODE
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [7:0]             cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // char_byte[7:0]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // cell_address[12:0], cell_word[28:13], cursor_column[35:29],
    // cursor_row[41:36], zero fill above
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [1:0]             m_axis_tuser,   // kind[1:0]
    output logic                   m_axis_tlast
);

    logic [7:0] columns_reg;
    logic [6:0] rows_reg;
    logic       q_full;
    logic       push;
    op_t        push_op;
    logic       pop;
    q_head_t    head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= COLUMNS_RST;
            rows_reg    <= ROWS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IDX_COLUMNS: columns_reg <= cfg_data;
                CFG_IDX_ROWS:    rows_reg    <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    tte_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_full        (q_full),
        .push          (push),
        .push_op       (push_op)
    );

    tte_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .full    (q_full),
        .pop     (pop),
        .head    (head)
    );

    tte_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .LEFT_CODE   (LEFT_CODE),
        .RIGHT_CODE  (RIGHT_CODE),
        .UP_CODE     (UP_CODE),
        .DOWN_CODE   (DOWN_CODE)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .columns       (columns_reg),
        .rows          (rows_reg),
        .head          (head),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
